FILE: rtl/core/stereo_to_mono_gate_gain_assert.svh
// Assertion macros used by the stereo-to-mono filter module.
`ifndef STEREO_TO_MONO_GATE_GAIN_ASSERT_SVH
`define STEREO_TO_MONO_GATE_GAIN_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define STMGG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define STMGG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/stmgg_pkg.sv
// Types and constants of the stereo-to-mono gate and gain block.
package stmgg_pkg;

    localparam int WORD_W       = 32;
    localparam int SAMPLE_W     = 24;
    localparam int OUT_W        = 16;
    localparam int GAIN_W       = 8;
    localparam int THR_W        = 24;
    localparam int CFG_DATA_W   = 24;
    localparam int REG_IDX_W    = 1;
    localparam int FILTER_SHIFT = 3;
    localparam int OUT_SHIFT    = 8;

    localparam logic [GAIN_W-1:0]       GAIN_RESET = GAIN_W'(4);
    localparam logic [THR_W-1:0]        THR_RESET  = THR_W'(16);
    localparam logic signed [OUT_W-1:0] OUT_MAX    = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN    = -16'sh8000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN           = 1'b0,
        REG_GATE_THRESHOLD = 1'b1
    } t_reg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

FILE: rtl/core/stmgg_filter.sv
// One-pole low-pass filter with noise gate; holds the filter state and the filtered sample.
module stmgg_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  stmgg_pkg::t_sample           i_left,
    input  stmgg_pkg::t_sample           i_right,
    input  logic [stmgg_pkg::THR_W-1:0]  i_thr,
    input  logic                         i_ready_dn,
    output logic                         o_ready_up,
    output logic                         o_valid,
    output stmgg_pkg::t_sample           o_y
);
    import stmgg_pkg::*;

    `include "stereo_to_mono_gate_gain_assert.svh"

    localparam int ACC_W = SAMPLE_W + FILTER_SHIFT + 1;
    localparam int CMP_W = THR_W + 2;

    logic                      r_valid;
    t_sample                   r_state;
    t_sample                   r_y;
    logic                      n_valid;
    t_sample                   n_state;
    t_sample                   n_y;
    logic                      take;
    logic signed [SAMPLE_W:0]  sum;
    t_sample                   mono;
    logic signed [ACC_W-1:0]   s_ext;
    logic signed [ACC_W-1:0]   acc;
    t_sample                   filt;
    logic signed [ACC_W-1:0]   f_ext;
    logic signed [ACC_W-1:0]   dec;
    logic signed [CMP_W-1:0]   thr_s;
    logic signed [CMP_W-1:0]   y_s;
    logic                      gated;

    assign o_ready_up = !r_valid || i_ready_dn;
    assign take       = i_valid && o_ready_up;
    assign o_valid    = r_valid;
    assign o_y        = r_y;

    always_comb begin
        sum   = (SAMPLE_W+1)'(i_left) + (SAMPLE_W+1)'(i_right);
        mono  = sum[SAMPLE_W:1];
        s_ext = ACC_W'(r_state);
        acc   = (s_ext <<< FILTER_SHIFT) - s_ext + ACC_W'(mono);
        filt  = acc[SAMPLE_W+FILTER_SHIFT-1:FILTER_SHIFT];
        f_ext = ACC_W'(filt);
        dec   = (f_ext <<< FILTER_SHIFT) - f_ext;
        thr_s = $signed({2'b00, i_thr});
        y_s   = CMP_W'(filt);
        gated = (y_s > -thr_s) && (y_s < thr_s);

        n_valid = r_valid;
        n_state = r_state;
        n_y     = r_y;
        if (take) begin
            n_valid = 1'b1;
            if (gated) begin
                n_state = dec[SAMPLE_W+FILTER_SHIFT-1:FILTER_SHIFT];
                n_y     = '0;
            end else begin
                n_state = filt;
                n_y     = filt;
            end
        end else if (i_ready_dn) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_state <= '0;
        end else begin
            r_valid <= n_valid;
            r_state <= n_state;
        end
        r_y <= n_y;
    end

    `STMGG_ASSERT(a_gate_gives_zero, (take && gated) |=> (r_valid && r_y == '0), "gated sample not zero")
    `STMGG_ASSERT(a_state_holds, (!take) |=> $stable(r_state), "filter state moved without a beat")
    `STMGG_ASSERT_RST(a_reset_clears, (!i_rst_n) |=> (!r_valid && r_state == '0), "reset did not clear filter")

endmodule

FILE: rtl/core/stmgg_gain.sv
// Gain multiply, shift and 16-bit saturation into the output register.
module stmgg_gain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  stmgg_pkg::t_sample            i_y,
    input  logic [stmgg_pkg::GAIN_W-1:0]  i_gain,
    output logic                          o_ready_up,
    output logic                          o_valid,
    output logic [stmgg_pkg::OUT_W-1:0]   o_data,
    input  logic                          i_ready_dn
);
    import stmgg_pkg::*;

    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    logic                     r_valid;
    logic [OUT_W-1:0]         r_data;
    logic                     n_valid;
    logic [OUT_W-1:0]         n_data;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;

    assign o_ready_up = !r_valid || i_ready_dn;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_comb begin
        prod    = PROD_W'(i_y) * PROD_W'($signed({1'b0, i_gain}));
        shifted = prod >>> OUT_SHIFT;
        n_valid = r_valid;
        n_data  = r_data;
        if (i_valid && o_ready_up) begin
            n_valid = 1'b1;
            priority if (shifted > PROD_W'(OUT_MAX)) begin
                n_data = OUT_MAX;
            end else if (shifted < PROD_W'(OUT_MIN)) begin
                n_data = OUT_MIN;
            end else begin
                n_data = shifted[OUT_W-1:0];
            end
        end else if (i_ready_dn) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

endmodule

FILE: rtl/core/stereo_to_mono_gate_gain.sv
// Top level of the stereo-to-mono converter with low-pass filter, noise gate and gain.
//
//  Channel   Direction  Payload                               Beat when
//  s_axis    in         tdata: left_word, right_word          tvalid & tready
//  m_axis    out        tdata: mono_sample                    tvalid & tready
//  cfg       in         index, data (gain, gate_threshold)    i_cfg_valid & o_cfg_ready
//
// A frame passes three registers: input register, filter stage (filter state recurrence
// computed combinationally within the stage), gain and saturation stage, whose register
// drives m_axis. One frame is accepted every cycle while the output side takes results.
// Each stage refills as soon as its content moves on, so stalls fill the stages first.
// Reset clears the filter state, the stage valid flags and the registers to their defaults.
module stereo_to_mono_gate_gain (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: left_word[31:0], right_word[63:32].
    input  logic [2*stmgg_pkg::WORD_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: mono_sample[15:0].
    output logic [stmgg_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stmgg_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [stmgg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import stmgg_pkg::*;

    logic              r_in_valid;
    t_sample           r_left;
    t_sample           r_right;
    logic [GAIN_W-1:0] r_gain;
    logic [THR_W-1:0]  r_thr;
    logic              filt_ready;
    logic              filt_valid;
    t_sample           filt_y;
    logic              gain_ready;

    assign s_axis_tready = !r_in_valid || filt_ready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_left  <= s_axis_tdata[WORD_W-1:WORD_W-SAMPLE_W];
            r_right <= s_axis_tdata[2*WORD_W-1:2*WORD_W-SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN:           r_gain <= i_cfg_data[GAIN_W-1:0];
                REG_GATE_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                default:            r_gain <= r_gain;
            endcase
        end
    end

    stmgg_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_left     (r_left),
        .i_right    (r_right),
        .i_thr      (r_thr),
        .i_ready_dn (gain_ready),
        .o_ready_up (filt_ready),
        .o_valid    (filt_valid),
        .o_y        (filt_y)
    );

    stmgg_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (filt_valid),
        .i_y        (filt_y),
        .i_gain     (r_gain),
        .o_ready_up (gain_ready),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .i_ready_dn (m_axis_tready)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the stereo-to-mono filter, noise gate and gain block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stmgg_pkg::*;

    typedef enum int {
        MIX_FULL,
        MIX_NEAR_GATE,
        MIX_DC
    } t_mix;

    localparam longint S24_MAX = 64'sd8388607;
    localparam longint S24_MIN = -64'sd8388608;
    localparam logic [THR_W-1:0] THR_TOP  = 24'h800000;
    localparam logic [THR_W-1:0] THR_FULL = 24'hFFFFFF;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [2*WORD_W-1:0]       s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_W-1:0]          m_axis_tdata;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [REG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data    = '0;

    logic [2*WORD_W-1:0]       frame_q[$];
    logic [OUT_W-1:0]          mono_expect_q[$];

    logic [GAIN_W-1:0]         gain_reg = GAIN_RESET;
    logic [THR_W-1:0]          gate_thr = THR_RESET;
    longint                    lp_state = 0;

    logic                      in_taken   = 1'b0;
    logic                      hold_rx    = 1'b0;
    logic                      tx_steady  = 1'b0;
    logic                      rx_steady  = 1'b0;
    int                        tx_wait    = 0;
    int                        rx_wait    = 0;

    int                        frames_in   = 0;
    int                        beats_out   = 0;
    int                        reg_writes  = 0;
    int                        gate_closed = 0;
    int                        saturated   = 0;
    int                        in_stalls   = 0;
    int                        err_count   = 0;

    stereo_to_mono_gate_gain u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [OUT_W-1:0] predict_mono(logic [2*WORD_W-1:0] frame);
        longint keep;
        longint left_s;
        longint right_s;
        longint avg;
        longint thr;
        longint y;
        keep    = (64'sd1 <<< FILTER_SHIFT) - 1;
        left_s  = longint'($signed(frame[WORD_W-1:WORD_W-SAMPLE_W]));
        right_s = longint'($signed(frame[2*WORD_W-1:2*WORD_W-SAMPLE_W]));
        avg     = (left_s + right_s) >>> 1;
        lp_state = (lp_state * keep + avg) >>> FILTER_SHIFT;
        thr = longint'(gate_thr);
        y   = lp_state;
        if (y > -thr && y < thr) begin
            lp_state = (lp_state * keep) >>> FILTER_SHIFT;
            y = 0;
            gate_closed++;
        end
        y = (y * longint'(gain_reg)) >>> OUT_SHIFT;
        if (y > longint'(OUT_MAX)) begin
            y = longint'(OUT_MAX);
            saturated++;
        end else if (y < longint'(OUT_MIN)) begin
            y = longint'(OUT_MIN);
            saturated++;
        end
        return y[OUT_W-1:0];
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] make_word(t_mix mix, longint level, longint amp);
        longint v;
        logic [SAMPLE_W-1:0] s;
        if (mix == MIX_FULL || (mix == MIX_NEAR_GATE && $urandom_range(0, 9) == 0)) begin
            return $urandom;
        end
        v = level + longint'($urandom_range(0, 32'(2 * amp))) - amp;
        if (v > S24_MAX) v = S24_MAX;
        if (v < S24_MIN) v = S24_MIN;
        s = v[SAMPLE_W-1:0];
        return {s, 8'($urandom)};
    endfunction

    // Sender: a new beat is offered only once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                s_axis_tdata  <= frame_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (!tx_steady) tx_wait = gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_rx) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_steady) rx_wait = gap_len();
        end
    end

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && !s_axis_tready) in_stalls++;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GAIN: begin
                        gain_reg = i_cfg_data[GAIN_W-1:0];
                    end
                    REG_GATE_THRESHOLD: begin
                        gate_thr = i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                mono_expect_q.push_back(predict_mono(s_axis_tdata));
                frames_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (mono_expect_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected mono beat %h with nothing pending", m_axis_tdata);
                    end
                end else begin
                    want = mono_expect_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mono beat %0d: expected %0d, got %0d", beats_out,
                                     $signed(want), $signed(m_axis_tdata));
                        end
                    end
                end
                beats_out++;
            end
        end
    end

    // Long receiver hold-off so that the pipeline fills and the input stalls.
    initial begin
        wait (frames_in >= 700 && frame_q.size() > 20);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        reg_writes++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while ((frame_q.size() != 0 || s_axis_tvalid || mono_expect_q.size() != 0)
                   && guard < 200000);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int            sent;
        int            count;
        int            r;
        t_mix          mix;
        longint        level;
        longint        amp;
        logic [GAIN_W-1:0] g;
        logic [THR_W-1:0]  t;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: full-scale ramps into both saturation limits, then decay into the gate.
        repeat (4) frame_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF});
        repeat (4) frame_q.push_back({32'h80000000, 32'h80000000});
        frame_q.push_back({32'h80000000, 32'h7FFFFFFF});
        frame_q.push_back({32'hFFFFFF00, 32'h000000FF});
        repeat (3) frame_q.push_back({32'h00000000, 32'h00000000});
        frame_q.push_back({32'hFFFFFFFF, 32'hFFFFFFFF});
        drain();

        // Zero threshold keeps the gate open; the gain write carries junk in the upper bits.
        write_reg(REG_GAIN, 24'hA55AFF);
        write_reg(REG_GATE_THRESHOLD, '0);
        frame_q.push_back({32'h00000000, 32'h00000000});
        frame_q.push_back({32'h00000100, 32'h00000100});
        frame_q.push_back({32'hFFFFFF00, 32'hFFFFFF00});
        drain();

        // Thresholds at and above the sample range close the gate on all but, for THR_TOP, the most negative sample.
        write_reg(REG_GATE_THRESHOLD, THR_TOP);
        repeat (3) frame_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF});
        drain();
        write_reg(REG_GATE_THRESHOLD, THR_FULL);
        repeat (2) frame_q.push_back({32'h80000000, 32'h80000000});
        drain();
        write_reg(REG_GAIN, '0);
        write_reg(REG_GATE_THRESHOLD, '0);
        repeat (2) frame_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF});
        drain();

        sent = 0;
        while (sent < 1950) begin
            r = $urandom_range(0, 99);
            g = (r < 15) ? '0 : (r < 30) ? '1 : GAIN_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 15) t = '0;
            else if (r < 25) t = THR_TOP;
            else if (r < 30) t = THR_FULL;
            else if (r < 65) t = THR_W'($urandom_range(1, 256));
            else t = THR_W'($urandom_range(1, 8388608));

            r = $urandom_range(0, 9);
            if (r < 2) begin
                write_reg(REG_GATE_THRESHOLD, t);
            end else if (r < 4) begin
                write_reg(REG_GAIN, {16'($urandom), g});
            end else if (r < 7) begin
                write_reg(REG_GAIN, {16'($urandom), g});
                write_reg(REG_GATE_THRESHOLD, t);
            end else begin
                write_reg(REG_GATE_THRESHOLD, t);
                write_reg(REG_GAIN, {16'($urandom), g});
            end

            r = $urandom_range(0, 99);
            mix = (r < 30) ? MIX_FULL : (r < 75) ? MIX_NEAR_GATE : MIX_DC;
            if (mix == MIX_DC) begin
                level = longint'($signed(24'($urandom)));
                amp   = 256;
            end else begin
                level = 0;
                amp   = (gate_thr == 0) ? 64 : longint'(gate_thr) * 3;
                if (amp > 4194304) amp = 4194304;
            end
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            count = $urandom_range(40, 160);
            if (count > 1950 - sent) count = 1950 - sent;
            repeat (count) begin
                frame_q.push_back({make_word(mix, level, amp), make_word(mix, level, amp)});
            end
            sent += count;
            drain();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();
        if (mono_expect_q.size() != 0) begin
            err_count += mono_expect_q.size();
            $display("%0d mono beats never arrived", mono_expect_q.size());
        end

        $display("summary: %0d frames in, %0d mono beats checked, %0d register writes",
                 frames_in, beats_out, reg_writes);
        $display("summary: %0d gated, %0d saturated, input stalled on %0d cycles, %0d errors",
                 gate_closed, saturated, in_stalls, err_count);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
